@@ rtl/core/spiq_pkg.sv @@
package spiq_pkg;

  // Default number of entries the store holds
  localparam int DEPTH_DEF = 16;

  // Field widths
  localparam int PRIO_W = 16;
  localparam int NAME_W = 24;
  localparam int POS_W  = 4;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - PRIO_W - NAME_W - POS_W;
  localparam int OUT_USER_W = 2;

  // Operation codes carried on the input tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  // One stored entry
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [NAME_W-1:0]        name;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_CMP,
    ST_PLACE,
    ST_LIST,
    ST_EMPTY
  } state_t;

endpackage

@@ rtl/core/spiq_store.sv @@
module spiq_store #(
  parameter int DEPTH = spiq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  spiq_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output spiq_pkg::entry_t  rd_data
);
  import spiq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/sorted_priority_insert_queue_core.sv @@
// Channel  Dir  Fields (tdata/tuser from bit 0 up)                Meaning
// s_*      in   tdata: priority_req, proc_name; tuser: opcode      one command
// m_*      out  tdata: entry_priority, entry_name, position;       one listed entry
//               tuser: is_empty, refused; tlast: last
//
// An insert reads and compares stored entries from the tail toward the head, plus a
// separate placement step for an entry at the head or into an empty store.
// The listing streams one entry per cycle while m_tready is high, and follows every insert.
// s_tready is high only while idle; a stalled m_tready pauses the listing.
// Reset empties the queue; the store contents need no clearing.
module sorted_priority_insert_queue_core #(
  parameter int DEPTH = spiq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [spiq_pkg::IN_DATA_W-1:0]   s_tdata,   // priority_req, proc_name
  input  logic                             s_tuser,   // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spiq_pkg::OUT_DATA_W-1:0]  m_tdata,   // entry_priority, entry_name, position
  output logic [spiq_pkg::OUT_USER_W-1:0]  m_tuser,   // is_empty, refused
  output logic                             m_tlast
);
  import spiq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_rank;
  logic             rd_valid;
  logic             refused;
  entry_t           new_entry;

  logic             in_xfer;
  logic             full;
  logic             out_free;
  logic             load;
  logic             issue;
  logic             last_rank;
  logic             greater;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  spiq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and shared compare
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign full      = (fill == CNT_W'(DEPTH));
  assign out_free  = !m_tvalid || m_tready;
  assign greater   = (rd_data.prio > new_entry.prio);
  assign load      = (state == ST_LIST) && rd_valid && out_free;
  assign issue     = (state == ST_LIST) && (rd_idx < fill) && (!rd_valid || load);
  assign last_rank = ((rd_rank + 1'b1) == fill);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((s_tuser == OP_INSERT) && !full) begin
            state_next = (fill == '0) ? ST_PLACE : ST_SHIFT_RD;
          end else begin
            state_next = (fill == '0) ? ST_EMPTY : ST_LIST;
          end
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_CMP;
      ST_SHIFT_CMP: begin
        if (greater) begin
          state_next = (cursor == CNT_W'(1)) ? ST_PLACE : ST_SHIFT_RD;
        end else begin
          state_next = ST_LIST;
        end
      end
      ST_PLACE: state_next = ST_LIST;
      ST_LIST: begin
        if (load && last_rank) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cursor[IDX_W-1:0];
    wr_data = new_entry;
    case (state)
      ST_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(cursor - 1'b1);
      end
      ST_SHIFT_CMP: begin
        wr_en   = 1'b1;
        wr_data = greater ? rd_data : new_entry;
      end
      ST_PLACE: wr_en = 1'b1;
      ST_LIST:  rd_en = issue;
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      rd_valid <= 1'b0;
      rd_idx   <= '0;
    end else begin
      state <= state_next;
      // count a completed insert
      if ((state == ST_PLACE) || ((state == ST_SHIFT_CMP) && !greater)) begin
        fill <= fill + 1'b1;
      end
      // advance the listing read pointer
      if (state != ST_LIST) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (load) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // Item and cursor registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      new_entry.prio <= s_tdata[PRIO_W-1:0];
      new_entry.name <= s_tdata[PRIO_W+NAME_W-1:PRIO_W];
      refused        <= (s_tuser == OP_INSERT) && full;
      cursor         <= fill;
    end else if ((state == ST_SHIFT_CMP) && greater) begin
      cursor <= cursor - 1'b1;
    end
    if (issue) begin
      rd_rank <= rd_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load || ((state == ST_EMPTY) && out_free)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {OUT_PAD_W'(0), POS_W'(rd_rank), rd_data.name, rd_data.prio};
      m_tuser <= {refused, 1'b0};
      m_tlast <= last_rank;
    end else if ((state == ST_EMPTY) && out_free) begin
      m_tdata <= '0;
      m_tuser <= {refused, 1'b1};
      m_tlast <= 1'b1;
    end
  end

endmodule
